// ===== rtl/wmm_pkg.sv =====
// Shared commands and character constants for the wildcard mask matcher.
`timescale 1ns / 1ps
package wmm_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_TEXT   = 2'd2;

  localparam logic [7:0] CHAR_A      = 8'h61;
  localparam int         ALPHA_COUNT = 26;
  localparam logic [7:0] CHAR_Z      = CHAR_A + 8'(ALPHA_COUNT - 1);
  localparam logic [7:0] CHAR_QMARK  = 8'h3F;

  localparam int POS_W = 32;

  // One decoded command, already qualified by the pipeline advancing.
  typedef struct packed {
    logic clear;
    logic append;
    logic text;
  } op_t;

endpackage

// ===== rtl/wildcard_mask_matcher.sv =====
// Top level of the streaming wildcard mask matcher.
`timescale 1ns / 1ps
// Load a mask with append commands (letters a..z match themselves, any other byte is a
// wildcard), then stream text bytes; each text byte that completes a window matching the
// whole mask produces one transfer carrying that window's start position. Clear empties
// the mask and restarts the position at zero. One item is taken every cycle unless the
// output stalls: the item is held in an input register while the per-entry compares and
// the shift-and vector update run, and the result goes to an output register, which lets
// a new item in while a result waits. MASK_MAX sets the mask capacity; symbols beyond it
// are ignored. The position saturates at all ones.
module wildcard_mask_matcher #(
  parameter int MASK_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_symbol,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [wmm_pkg::POS_W-1:0] out_match_start
);
  import wmm_pkg::*;

  localparam int LW = $clog2(MASK_MAX + 1);

  logic                s1_valid_r;
  logic [1:0]          s1_cmd_r;
  logic [7:0]          s1_sym_r;
  logic                out_valid_r;
  logic [POS_W-1:0]    out_start_r;
  logic                out_load;
  logic                proc;
  op_t                 op;
  logic [LW-1:0]       len;
  logic [MASK_MAX-1:0] cell_ok;
  logic                hit;
  logic [POS_W-1:0]    start;

  assign out_load = !out_valid_r || out_ready;
  assign proc     = s1_valid_r && out_load;
  assign in_ready = !s1_valid_r || out_load;

  assign op.clear  = proc && (s1_cmd_r == CMD_CLEAR);
  assign op.append = proc && (s1_cmd_r == CMD_APPEND);
  assign op.text   = proc && (s1_cmd_r == CMD_TEXT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (proc) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r <= in_command;
      s1_sym_r <= in_symbol;
    end
  end

  wmm_mask_bank #(
    .MASK_MAX(MASK_MAX),
    .LW(LW)
  ) u_bank (
    .clk(clk),
    .rst_n(rst_n),
    .op(op),
    .symbol(s1_sym_r),
    .len(len),
    .cell_ok(cell_ok)
  );

  wmm_track #(
    .MASK_MAX(MASK_MAX),
    .LW(LW)
  ) u_track (
    .clk(clk),
    .rst_n(rst_n),
    .op(op),
    .len(len),
    .cell_ok(cell_ok),
    .hit(hit),
    .start(start)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= op.text && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_start_r <= start;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_start = out_start_r;

endmodule

// ===== rtl/wmm_mask_bank.sv =====
// Mask symbol storage, length counter and per-entry symbol compare.
`timescale 1ns / 1ps
module wmm_mask_bank #(
  parameter int MASK_MAX = 64,
  parameter int LW = $clog2(MASK_MAX + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wmm_pkg::op_t      op,
  input  logic [7:0]        symbol,
  output logic [LW-1:0]     len,
  output logic [MASK_MAX-1:0] cell_ok
);
  import wmm_pkg::*;

  localparam int IW = (MASK_MAX > 1) ? $clog2(MASK_MAX) : 1;

  logic [7:0]    mask_r [MASK_MAX];
  logic [LW-1:0] len_r;
  logic [LW-1:0] len_nxt;
  logic          not_full;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [7:0]    wr_data;

  assign not_full = len_r < LW'(MASK_MAX);
  assign wr_en    = op.append && not_full;
  assign wr_addr  = len_r[IW-1:0];
  // anything outside a..z is stored as a wildcard
  assign wr_data  = (symbol >= CHAR_A && symbol <= CHAR_Z) ? symbol : CHAR_QMARK;

  always_comb begin
    len_nxt = len_r;
    if (op.clear) begin
      len_nxt = '0;
    end else if (wr_en) begin
      len_nxt = len_r + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mask_r[wr_addr] <= wr_data;
    end
  end

  // entries at or above the length never qualify, so unwritten ones are masked off
  always_comb begin
    for (int k = 0; k < MASK_MAX; k++) begin
      cell_ok[k] = (LW'(k) < len_r) &&
                   ((mask_r[k] == CHAR_QMARK) || (mask_r[k] == symbol));
    end
  end

  assign len = len_r;

endmodule

// ===== rtl/wmm_track.sv =====
// Shift-and match vector, text position counter and match start calculation.
`timescale 1ns / 1ps
module wmm_track #(
  parameter int MASK_MAX = 64,
  parameter int LW = $clog2(MASK_MAX + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wmm_pkg::op_t            op,
  input  logic [LW-1:0]           len,
  input  logic [MASK_MAX-1:0]     cell_ok,
  output logic                    hit,
  output logic [wmm_pkg::POS_W-1:0] start
);
  import wmm_pkg::*;

  localparam int IW = (MASK_MAX > 1) ? $clog2(MASK_MAX) : 1;

  logic [MASK_MAX-1:0] active_r;
  logic [MASK_MAX-1:0] active_nxt;
  logic [POS_W-1:0]    pos_r;
  logic [POS_W-1:0]    pos_nxt;
  logic [LW-1:0]       len_m1;
  logic [IW-1:0]       last_idx;

  // prefix k extends only if prefix k-1 ended on the previous symbol
  always_comb begin
    for (int k = 0; k < MASK_MAX; k++) begin
      if (k == 0) begin
        active_nxt[k] = cell_ok[k];
      end else begin
        active_nxt[k] = cell_ok[k] && active_r[k-1];
      end
    end
  end

  assign len_m1   = len - LW'(1);
  assign last_idx = len_m1[IW-1:0];
  assign hit      = (len != '0) && active_nxt[last_idx];
  assign start    = pos_r - POS_W'(len_m1);

  always_comb begin
    pos_nxt = pos_r;
    if (op.clear) begin
      pos_nxt = '0;
    end else if (op.text && (pos_r != '1)) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // bits at or above the length stay clear, so an append needs no vector update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      pos_r    <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (op.clear) begin
        active_r <= '0;
      end else if (op.text) begin
        active_r <= active_nxt;
      end
    end
  end

  a_above_len_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r >> len) == {MASK_MAX{1'b0}})
    else $error("match vector bit set at or above mask length");

  a_pos_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    !op.clear |=> pos_r >= $past(pos_r))
    else $error("text position moved backward without clear");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    op.clear |=> (active_r == {MASK_MAX{1'b0}}) && (pos_r == '0) && (len == '0))
    else $error("clear left state behind");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the wildcard mask matcher.
`timescale 1ns / 1ps
module tb_top;
  import wmm_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         MASK_CAP     = 64;
  localparam int         TOTAL_ITEMS  = 925;
  localparam int         HOLD_AFTER   = 250;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         DRAIN_CYCLES = 12;
  localparam int         CYCLE_LIMIT  = 200_000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_command = CMD_CLEAR;
  logic [7:0]       in_symbol = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [POS_W-1:0] out_match_start;

  // no-idle stretch and receiver hold-off, both changed only by NBA
  logic calm = 1'b0;
  logic hold_off = 1'b0;

  // matcher model state
  logic [7:0]       mask_sym [MASK_CAP];
  int unsigned      mask_len;
  logic [63:0]      prefix_hits;
  logic [POS_W-1:0] text_pos;

  logic [POS_W-1:0] expected_starts [$];
  int unsigned      item_count = 0;
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       sym;
    logic             fixed;
    logic             fixed_hit;
    logic [POS_W-1:0] fixed_start;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{CMD_TEXT,   CHAR_A,     1'b1, 1'b0, 32'd0},  // empty mask: nothing
    '{CMD_APPEND, 8'h00,      1'b0, 1'b0, 32'd0},  // non-letter mask byte -> wildcard
    '{CMD_TEXT,   8'hFF,      1'b1, 1'b1, 32'd1},
    '{CMD_CLEAR,  8'hFF,      1'b0, 1'b0, 32'd0},
    '{CMD_APPEND, CHAR_A,     1'b0, 1'b0, 32'd0},
    '{CMD_APPEND, CHAR_Z,     1'b0, 1'b0, 32'd0},
    '{CMD_APPEND, CHAR_QMARK, 1'b0, 1'b0, 32'd0},
    '{CMD_TEXT,   CHAR_A,     1'b0, 1'b0, 32'd0},
    '{CMD_TEXT,   CHAR_Z,     1'b0, 1'b0, 32'd0},
    '{CMD_TEXT,   8'h7B,      1'b1, 1'b1, 32'd0},  // non-letter text under wildcard
    '{CMD_TEXT,   8'h60,      1'b0, 1'b0, 32'd0},
    '{CMD_APPEND, 8'hFF,      1'b0, 1'b0, 32'd0},  // append after text
    '{CMD_TEXT,   CHAR_A,     1'b0, 1'b0, 32'd0},
    '{CMD_UNUSED, 8'hAA,      1'b0, 1'b0, 32'd0},
    '{CMD_TEXT,   CHAR_Z,     1'b0, 1'b0, 32'd0},
    '{CMD_TEXT,   8'h5A,      1'b0, 1'b0, 32'd0},
    '{CMD_TEXT,   8'h00,      1'b0, 1'b0, 32'd0},
    '{CMD_CLEAR,  8'h00,      1'b0, 1'b0, 32'd0},
    '{CMD_APPEND, 8'h71,      1'b0, 1'b0, 32'd0},
    '{CMD_TEXT,   8'h71,      1'b1, 1'b1, 32'd0},
    '{CMD_TEXT,   8'h71,      1'b1, 1'b1, 32'd1},
    '{CMD_TEXT,   8'h70,      1'b1, 1'b0, 32'd0},  // letter vs other letter
    '{CMD_APPEND, 8'h60,      1'b0, 1'b0, 32'd0},
    '{CMD_TEXT,   8'h71,      1'b0, 1'b0, 32'd0},
    '{CMD_TEXT,   8'h80,      1'b0, 1'b0, 32'd0}
  };

  wildcard_mask_matcher DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_symbol       (in_symbol),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_start (out_match_start)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void clear_matcher();
    prefix_hits = '0;
    mask_len    = 0;
    text_pos    = '0;
  endfunction

  // append one expected start at the tail of the scoreboard
  function automatic void queue_expected(input logic [POS_W-1:0] s);
    expected_starts = {expected_starts, s};
  endfunction

  // Shift-and update for one item; returns 1 when a full window ends here.
  function automatic bit advance_matcher(input logic [1:0] cmd, input logic [7:0] sym,
                                         output logic [POS_W-1:0] start);
    bit prev;
    bit hit;
    hit   = 1'b0;
    start = '0;
    case (cmd)
      CMD_CLEAR: begin
        clear_matcher();
      end
      CMD_APPEND: begin
        if (mask_len < MASK_CAP) begin
          mask_sym[mask_len]    = (sym >= CHAR_A && sym <= CHAR_Z) ? sym : CHAR_QMARK;
          prefix_hits[mask_len] = 1'b0;
          mask_len++;
        end
      end
      CMD_TEXT: begin
        for (int k = int'(mask_len) - 1; k >= 0; k--) begin
          prev = (k == 0) ? 1'b1 : prefix_hits[k-1];
          prefix_hits[k] = prev && (mask_sym[k] == CHAR_QMARK || mask_sym[k] == sym);
        end
        hit = (mask_len > 0) && prefix_hits[mask_len-1];
        start = text_pos - POS_W'(mask_len - 1);
        if (text_pos != '1) text_pos++;
      end
      default: ;
    endcase
    return hit;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] sym);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_symbol  <= sym;
    do @(posedge clk); while (!in_ready);
    if (cmd != CMD_UNUSED) item_count++;
  endtask

  task automatic feed(input logic [1:0] cmd, input logic [7:0] sym);
    logic [POS_W-1:0] start;
    send_item(cmd, sym);
    if (advance_matcher(cmd, sym, start)) queue_expected(start);
  endtask

  function automatic logic [7:0] pick_mask_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return CHAR_A + 8'($urandom_range(2));
    if (r < 8) return CHAR_A + 8'($urandom_range(ALPHA_COUNT - 1));
    if (r == 8) return CHAR_QMARK;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 7) return CHAR_A + 8'($urandom_range(2));
    if (r == 7) return CHAR_A + 8'($urandom_range(ALPHA_COUNT - 1));
    return 8'($urandom_range(255));
  endfunction

  // Stream one copy of the current mask, wildcards filled with random bytes,
  // sometimes with one symbol broken.
  task automatic embed_mask();
    int   bad;
    int   len;
    logic [7:0] b;
    len = int'(mask_len);
    bad = ($urandom_range(11) == 0 && len > 0) ? $urandom_range(len - 1) : -1;
    for (int k = 0; k < len; k++) begin
      b = (mask_sym[k] == CHAR_QMARK) ? 8'($urandom_range(255)) : mask_sym[k];
      if (k == bad) b = b ^ 8'h01;
      feed(CMD_TEXT, b);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [POS_W-1:0] exp_v,
                               input logic [POS_W-1:0] act_v);
    if (mismatch_count < 10)
      $display("[%0t] mismatch: %s expected %0d actual %0d", $realtime, what, exp_v, act_v);
    mismatch_count++;
  endtask

  // result side: check each transfer, then pick next ready
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_starts.size() == 0) begin
          note_mismatch("unexpected match_start", '0, out_match_start);
        end else begin
          if (out_match_start !== expected_starts[0])
            note_mismatch("match_start", expected_starts[0], out_match_start);
          void'(expected_starts.pop_front());
        end
      end
      out_ready <= !hold_off && (calm || $urandom_range(99) >= 9);
    end
  end

  // long receiver stall while the sender keeps going
  initial begin
    while (item_count < HOLD_AFTER) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int unsigned roll;
    int unsigned span;
    clear_matcher();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      logic [POS_W-1:0] start;
      bit hit;
      send_item(DIR_TABLE[i].cmd, DIR_TABLE[i].sym);
      hit = advance_matcher(DIR_TABLE[i].cmd, DIR_TABLE[i].sym, start);
      if (DIR_TABLE[i].fixed) begin
        hit   = DIR_TABLE[i].fixed_hit;
        start = DIR_TABLE[i].fixed_start;
      end
      if (hit) queue_expected(start);
    end

    while (item_count < TOTAL_ITEMS) begin
      calm <= (item_count >= 400 && item_count < 600);
      roll = $urandom_range(99);
      if (roll < 78) begin
        // well-formed: (usually) clear, load a mask, stream text, often with copies of it
        if ($urandom_range(9) != 0) feed(CMD_CLEAR, 8'($urandom_range(255)));
        span = ($urandom_range(29) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 6);
        repeat (span) feed(CMD_APPEND, pick_mask_byte());
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(1) == 0) embed_mask();
          else repeat ($urandom_range(1, 4)) feed(CMD_TEXT, pick_text_byte());
        end
        if ($urandom_range(9) == 0) begin
          feed(CMD_APPEND, pick_mask_byte());
          feed(CMD_TEXT, pick_text_byte());
          embed_mask();
        end
      end else begin
        repeat ($urandom_range(1, 5))
          feed(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    while (expected_starts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_starts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wmm_pkg.sv
rtl/wmm_mask_bank.sv
rtl/wmm_track.sv
rtl/wildcard_mask_matcher.sv
dv/tb_top.sv
